### hw/rtl/segsph_pkg.sv
// ----------------------------------------------------------------------------
// segsph_pkg
// Shared widths, register indexes and request types for the segment versus
// sphere hit test pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package segsph_pkg;

  // Fraction bits of all coordinates and of the segment parameter t
  localparam int FRAC_BITS = 16;

  localparam int CRD_W = 32;                 // coordinate width
  localparam int RAD_W = 31;                 // radius width
  localparam int DIF_W = CRD_W + 1;          // exact difference of two coordinates
  localparam int PRD_W = 2 * DIF_W;          // signed product of two differences
  localparam int DOT_W = PRD_W + 2;          // signed sum of three products
  localparam int DD_W  = PRD_W + 1;          // unsigned sum of three squares
  localparam int RR_W  = 2 * RAD_W;          // squared radius
  localparam int T_W   = FRAC_BITS + 1;      // t in [0, 1.0]
  localparam int TD_W  = T_W + 1 + DIF_W;    // signed t * D product

  // Configuration register indexes
  localparam int IDX_W = 3;
  typedef enum logic [IDX_W-1:0] {
    REG_NEAR_X = 3'd0,
    REG_NEAR_Y = 3'd1,
    REG_NEAR_Z = 3'd2,
    REG_FAR_X  = 3'd3,
    REG_FAR_Y  = 3'd4,
    REG_FAR_Z  = 3'd5
  } reg_idx_t;

  typedef logic signed [CRD_W-1:0] crd_t;
  typedef logic signed [DIF_W-1:0] dif_t;

  // Segment endpoints, index 0..2 = x, y, z
  typedef struct packed {
    crd_t [2:0] near;
    crd_t [2:0] far;
  } seg_t;

  // One sphere request
  typedef struct packed {
    crd_t [2:0]       c;
    logic [RAD_W-1:0] rad;
    logic             pk;
  } sphere_t;

  // Front end to divider: projection numerator and carried terms
  typedef struct packed {
    logic signed [DOT_W-1:0] pd;
    dif_t [2:0]              p;
    logic [RR_W-1:0]         rr;
    logic                    pk;
  } dot_t;

  // Divider to back end: clamped segment parameter and carried terms
  typedef struct packed {
    logic [T_W-1:0]  t;
    dif_t [2:0]      p;
    logic [RR_W-1:0] rr;
    logic            pk;
  } tpar_t;

endpackage

### hw/rtl/segsph_front.sv
// ----------------------------------------------------------------------------
// segsph_front
// Three-stage front end: P = C - A, products P*D and D*D, then the dot
// products P.D (per request) and D.D (from the segment registers).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segsph_front
  import segsph_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sphere_t             in_item,
  input  seg_t                seg,
  output logic                out_valid,
  input  logic                out_ready,
  output dot_t                out_item,
  output dif_t [2:0]          dir,
  output logic [DD_W-1:0]     dd
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  dif_t [2:0]              p1, p2, p3;
  logic [RAD_W-1:0]        r1;
  logic                    pk1, pk2, pk3;
  logic signed [PRD_W-1:0] pdp2 [3];
  logic [RR_W-1:0]         rr2, rr3;
  logic signed [DOT_W-1:0] pd3;

  dif_t [2:0]              d_reg;
  logic signed [PRD_W-1:0] ddp [3];
  logic [DD_W-1:0]         dd_reg;

  // Stage enables: a stage moves when empty or when the next one moves
  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Segment direction and its squared length, free running; the user must let the
  // registers change only while the pipeline is empty, the block does not enforce it
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_reg[i] <= {seg.far[i][CRD_W-1], seg.far[i]} - {seg.near[i][CRD_W-1], seg.near[i]};
      ddp[i]   <= $signed(d_reg[i]) * $signed(d_reg[i]);
    end
    dd_reg <= DD_W'(ddp[0][PRD_W-2:0]) + DD_W'(ddp[1][PRD_W-2:0])
            + DD_W'(ddp[2][PRD_W-2:0]);
  end

  // Stage 1: center relative to the segment start
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        p1[i] <= {in_item.c[i][CRD_W-1], in_item.c[i]}
               - {seg.near[i][CRD_W-1], seg.near[i]};
      end
      r1  <= in_item.rad;
      pk1 <= in_item.pk;
    end
  end

  // Stage 2: per-axis products and squared radius
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        pdp2[i] <= $signed(p1[i]) * $signed(d_reg[i]);
      end
      rr2 <= RR_W'(r1) * RR_W'(r1);
      p2  <= p1;
      pk2 <= pk1;
    end
  end

  // Stage 3: sum to P.D
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      pd3 <= DOT_W'(pdp2[0]) + DOT_W'(pdp2[1]) + DOT_W'(pdp2[2]);
      rr3 <= rr2;
      p3  <= p2;
      pk3 <= pk2;
    end
  end

  assign out_valid   = v3;
  assign out_item.pd = pd3;
  assign out_item.p  = p3;
  assign out_item.rr = rr3;
  assign out_item.pk = pk3;
  assign dir         = d_reg;
  assign dd          = dd_reg;

`ifndef SYNTHESIS
  // An empty first stage always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> in_ready)
    else $error("front: empty first stage refuses a request");

  // A blocked last stage keeps its request
  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    v3 && !out_ready |=> v3 && $stable(pd3) && $stable(pk3))
    else $error("front: blocked request lost or changed");
`endif

endmodule

### hw/rtl/segsph_div.sv
// ----------------------------------------------------------------------------
// segsph_div
// Clamp and pipelined restoring divider: t = floor(P.D * 2^FRAC_BITS / D.D)
// for 0 < P.D < D.D, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segsph_div
  import segsph_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dot_t            in_item,
  input  logic [DD_W-1:0] dd,
  output logic            out_valid,
  input  logic            out_ready,
  output tpar_t           out_item
);

  // Stage 0 classifies, stages 1..FRAC_BITS each produce one quotient bit
  localparam int NST = FRAC_BITS + 1;

  logic                 v    [NST];
  logic                 en   [NST];
  logic [DD_W-1:0]      rem  [NST];
  logic [FRAC_BITS-1:0] q    [NST];
  logic                 zf   [NST];  // t clamps to zero
  logic                 of   [NST];  // t clamps to one
  dif_t [2:0]           p    [NST];
  logic [RR_W-1:0]      rr   [NST];
  logic                 pk   [NST];

  logic pd_pos, pd_ge;

  // Enable chain
  assign en[NST-1] = !v[NST-1] || out_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign in_ready = en[0];

  // Clamp decisions
  assign pd_pos = !in_item.pd[DOT_W-1] && (in_item.pd != '0);
  assign pd_ge  = $unsigned(in_item.pd) >= {{(DOT_W-DD_W){1'b0}}, dd};

  // Stage 0
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
    if (en[0]) begin
      zf[0]  <= !pd_pos;
      of[0]  <= pd_pos && pd_ge;
      rem[0] <= in_item.pd[DD_W-1:0];
      q[0]   <= '0;
      p[0]   <= in_item.p;
      rr[0]  <= in_item.rr;
      pk[0]  <= in_item.pk;
    end
  end

  // Restoring steps
  for (genvar k = 1; k < NST; k++) begin : g_step
    logic [DD_W:0] sh, df;
    logic          ge;

    assign sh = {rem[k-1], 1'b0};
    assign ge = sh >= {1'b0, dd};
    assign df = sh - {1'b0, dd};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v[k-1];
      end
      if (en[k]) begin
        rem[k] <= ge ? df[DD_W-1:0] : sh[DD_W-1:0];
        q[k]   <= {q[k-1][FRAC_BITS-2:0], ge};
        zf[k]  <= zf[k-1];
        of[k]  <= of[k-1];
        p[k]   <= p[k-1];
        rr[k]  <= rr[k-1];
        pk[k]  <= pk[k-1];
      end
    end
  end

  // Clamped parameter and carried terms
  always_comb begin
    out_item.p  = p[NST-1];
    out_item.rr = rr[NST-1];
    out_item.pk = pk[NST-1];
    priority if (of[NST-1]) begin
      out_item.t = T_W'(1) << FRAC_BITS;
    end else if (zf[NST-1]) begin
      out_item.t = '0;
    end else begin
      out_item.t = {1'b0, q[NST-1]};
    end
  end

  assign out_valid = v[NST-1];

`ifndef SYNTHESIS
  // A blocked classify stage keeps its request
  a_hold_first: assert property (@(posedge clk) disable iff (rst)
    !en[0] |=> v[0] && $stable(rem[0]) && $stable(zf[0]) && $stable(of[0]))
    else $error("div: blocked request lost or changed");

  // t never exceeds one
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.t[FRAC_BITS] |-> out_item.t[FRAC_BITS-1:0] == '0)
    else $error("div: t above one");
`endif

endmodule

### hw/rtl/segsph_back.sv
// ----------------------------------------------------------------------------
// segsph_back
// Five-stage back end: t*D, E = P - floor(t*D), squares, |E|^2, and the
// compare against R^2 into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segsph_back
  import segsph_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  tpar_t      in_item,
  input  dif_t [2:0] dir,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       hit
);

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  logic signed [TD_W-1:0]  tdp [3];
  logic signed [TD_W-1:0]  ediff [3];
  dif_t                    e2 [3];
  logic signed [PRD_W-1:0] esq [3];
  logic [DD_W-1:0]         dist_sq;
  dif_t [2:0]              p1;
  logic [RR_W-1:0]         rr1, rr2, rr3, rr4;
  logic                    pk1, pk2, pk3, pk4;
  logic                    hit_r;

  assign en5      = !v5 || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Stage 1: t * D
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        tdp[i] <= $signed({1'b0, in_item.t}) * $signed(dir[i]);
      end
      p1  <= in_item.p;
      rr1 <= in_item.rr;
      pk1 <= in_item.pk;
    end
  end

  // E = (C - A) - floor(t * D); fits DIF_W since Q lies between A and B
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ediff[i] = TD_W'($signed(p1[i])) - (tdp[i] >>> FRAC_BITS);
    end
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        e2[i] <= ediff[i][DIF_W-1:0];
      end
      rr2 <= rr1;
      pk2 <= pk1;
    end
  end

  // Stage 3: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        esq[i] <= $signed(e2[i]) * $signed(e2[i]);
      end
      rr3 <= rr2;
      pk3 <= pk2;
    end
  end

  // Stage 4: squared distance
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
    if (en4) begin
      dist_sq <= DD_W'(esq[0][PRD_W-2:0]) + DD_W'(esq[1][PRD_W-2:0])
               + DD_W'(esq[2][PRD_W-2:0]);
      rr4     <= rr3;
      pk4     <= pk3;
    end
  end

  // Stage 5: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en5) begin
      v5 <= v4;
    end
    if (en5) begin
      hit_r <= pk4 && (dist_sq <= DD_W'(rr4));
    end
  end

  assign out_valid = v5;
  assign hit       = hit_r;

`ifndef SYNTHESIS
  // A result appears only behind a request in the distance stage
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v4))
    else $error("back: result without a request");
`endif

endmodule

### hw/rtl/segment_sphere_hit_test_top.sv
// ----------------------------------------------------------------------------
// segment_sphere_hit_test_top
// Throughput: one sphere per cycle while out_stall is low; the divider resolves
// one quotient bit per stage and every stage is its own register slice.
// Reset: synchronous, clears all stage valid bits and the six endpoint
// registers to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_sphere_hit_test_top
  import segsph_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CRD_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CRD_W-1:0] center_x,
  input  logic signed [CRD_W-1:0] center_y,
  input  logic signed [CRD_W-1:0] center_z,
  input  logic [RAD_W-1:0]        sphere_radius,
  input  logic                    pickable,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    hit
);

  seg_t            seg;
  sphere_t         sph;
  dot_t            dot_item;
  tpar_t           t_item;
  dif_t [2:0]      dir;
  logic [DD_W-1:0] dd;
  logic            fr_ready, fr_valid;
  logic            dv_ready, dv_valid;
  logic            bk_ready;

  // Endpoint registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NEAR_X: seg.near[0] <= cfg_data;
        REG_NEAR_Y: seg.near[1] <= cfg_data;
        REG_NEAR_Z: seg.near[2] <= cfg_data;
        REG_FAR_X:  seg.far[0]  <= cfg_data;
        REG_FAR_Y:  seg.far[1]  <= cfg_data;
        REG_FAR_Z:  seg.far[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sph.c[0] = center_x;
  assign sph.c[1] = center_y;
  assign sph.c[2] = center_z;
  assign sph.rad  = sphere_radius;
  assign sph.pk   = pickable;
  assign in_stall = !fr_ready;

  segsph_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (fr_ready),
    .in_item   (sph),
    .seg       (seg),
    .out_valid (fr_valid),
    .out_ready (dv_ready),
    .out_item  (dot_item),
    .dir       (dir),
    .dd        (dd)
  );

  segsph_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (dv_ready),
    .in_item   (dot_item),
    .dd        (dd),
    .out_valid (dv_valid),
    .out_ready (bk_ready),
    .out_item  (t_item)
  );

  segsph_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_ready  (bk_ready),
    .in_item   (t_item),
    .dir       (dir),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .hit       (hit)
  );

endmodule

### tb/segment_sphere_hit_test_top_tb.sv
// ----------------------------------------------------------------------------
// segment_sphere_hit_test_top_tb
// Self-checking bench for the segment versus sphere hit test pipeline. A
// directed table covers the zero-length segment after reset, field extremes,
// spheres behind the start, beyond the end and along the segment, and spheres
// that cannot be picked. Random spheres follow under several segment settings.
// Most of them lie close to the segment so that hits and misses both occur.
// Every result is compared in order against the table's hit or a bit-exact hit predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_sphere_hit_test_top_tb;
  import segsph_pkg::*;

  localparam crd_t ONE   = 32'sd65536;                 // 1.0 in Q16.16
  localparam crd_t C_MAX = 32'sh7fffffff;
  localparam crd_t C_MIN = 32'sh80000000;
  localparam logic [RAD_W-1:0] R_MAX = {RAD_W{1'b1}};
  localparam logic [IDX_W-1:0] IDX_SPARE_A = 3'd6;      // unmapped register slots
  localparam logic [IDX_W-1:0] IDX_SPARE_B = 3'd7;
  localparam int N_DIR            = 18;
  localparam int NUM_PHASES       = 8;
  localparam int ITEMS_PER_PHASE  = 85;
  localparam int DRAIN_CYCLES     = FRAC_BITS + 24;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    int unsigned id;
    bit          hit;
  } pending_hit_t;

  // one directed request; seg_ten selects the 10.0 long segment along x
  typedef struct packed {
    logic             seg_ten;
    crd_t             cx;
    crd_t             cy;
    crd_t             cz;
    logic [RAD_W-1:0] r;
    logic             pk;
    logic             typed;
    logic             hit;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_write;
  logic [IDX_W-1:0]        cfg_index;
  logic [CRD_W-1:0]        cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [CRD_W-1:0] center_x;
  logic signed [CRD_W-1:0] center_y;
  logic signed [CRD_W-1:0] center_z;
  logic [RAD_W-1:0]        sphere_radius;
  logic                    pickable;
  logic                    out_valid;
  logic                    out_stall;
  logic                    hit;

  crd_t         endpoints [6];      // copy of near xyz, far xyz
  pending_hit_t pending_hits [$];
  dir_row_t     dir_rows [N_DIR];
  int unsigned  err_count;
  int unsigned  sent_count;
  int unsigned  result_count;
  int unsigned  hit_count;
  int unsigned  seg_settings;
  int           burst_left;
  stall_mode_t  stall_mode;
  int           stall_mode_left;
  int unsigned  cycle_count;

  segment_sphere_hit_test_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .sphere_radius (sphere_radius),
    .pickable      (pickable),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Closest point on the clamped segment, then squared distance vs squared radius
  function automatic bit predict_hit(input sphere_t s);
    logic signed [127:0] a [3];
    logic signed [127:0] d [3];
    logic signed [127:0] p [3];
    logic signed [127:0] dd, pd, t, q, e, dist_sq, rr;
    dd = 0;
    pd = 0;
    for (int k = 0; k < 3; k++) begin
      a[k] = endpoints[k];
      d[k] = endpoints[3 + k];
      d[k] = d[k] - a[k];
      p[k] = s.c[k];
      p[k] = p[k] - a[k];
      dd += d[k] * d[k];
      pd += p[k] * d[k];
    end
    if (pd <= 0) begin
      t = 0;
    end else if (pd >= dd) begin
      t = 128'sd1 <<< FRAC_BITS;
    end else begin
      t = (pd <<< FRAC_BITS) / dd;
    end
    dist_sq = 0;
    for (int k = 0; k < 3; k++) begin
      q = a[k] + ((t * d[k]) >>> FRAC_BITS);   // floor toward minus infinity
      e = s.c[k];
      e = e - q;
      dist_sq += e * e;
    end
    rr = 128'(s.rad);
    rr = rr * rr;
    return s.pk && (dist_sq <= rr);
  endfunction

  function automatic crd_t rand_crd(input int unsigned span_bits);
    longint half;
    if (span_bits >= 32) return crd_t'($urandom);
    half = longint'(1) << (span_bits - 1);
    return crd_t'(longint'($urandom_range(0, 32'((half << 1) - 1))) - half);
  endfunction

  function automatic crd_t clamp_crd(input longint v);
    if (v > longint'(C_MAX)) return C_MAX;
    if (v < longint'(C_MIN)) return C_MIN;
    return crd_t'(v);
  endfunction

  task automatic write_endpoint(input logic [IDX_W-1:0] idx, input logic [CRD_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    if (idx <= REG_FAR_Z) endpoints[idx] = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic load_segment(input crd_t nx, ny, nz, fx, fy, fz);
    write_endpoint(REG_NEAR_X, nx);
    write_endpoint(REG_NEAR_Y, ny);
    write_endpoint(REG_NEAR_Z, nz);
    write_endpoint(REG_FAR_X, fx);
    write_endpoint(REG_FAR_Y, fy);
    write_endpoint(REG_FAR_Z, fz);
    seg_settings++;
  endtask

  // hold off requests until every pending result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    burst_left = 0;
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  // Send one request in bursts with random gaps; record the expected hit
  task automatic send_sphere(input sphere_t s, input bit typed, input bit typed_hit);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    center_x      = s.c[0];
    center_y      = s.c[1];
    center_z      = s.c[2];
    sphere_radius = s.rad;
    pickable      = s.pk;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    pending_hits.push_back('{id: sent_count, hit: typed ? typed_hit : predict_hit(s)});
    sent_count++;
  endtask

  // Receiver stall pattern, switching at random among four modes
  always @(negedge clk) begin
    cycle_count++;
    if (stall_mode_left == 0) begin
      stall_mode      = stall_mode_t'($urandom_range(0, 3));
      stall_mode_left = $urandom_range(32, 200);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      STALL_NONE:     out_stall = 1'b0;
      STALL_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall = ($urandom_range(0, 9) < 7);
      STALL_PERIODIC: out_stall = (cycle_count % 4 == 0);
      default:        out_stall = 1'b0;
    endcase
  end

  // Result check against the oldest pending expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        report_mismatch($sformatf("result hit=%b with no request pending", hit));
      end else begin
        if (hit !== pending_hits[0].hit)
          report_mismatch($sformatf("request %0d: hit=%b, expected %b",
                                    pending_hits[0].id, hit, pending_hits[0].hit));
        void'(pending_hits.pop_front());
      end
      result_count++;
      if (hit === 1'b1) hit_count++;
    end
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("segment_sphere_hit_test_top_tb: done, errors");
    $finish;
  end

  initial begin
    sphere_t     s;
    bit          seg_ten_loaded;
    int unsigned kind;
    int unsigned scale_bits;
    longint      tq, av, dv, rad_v;
    crd_t        nx, ny, nz;

    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    center_x      = '0;
    center_y      = '0;
    center_z      = '0;
    sphere_radius = '0;
    pickable      = 1'b0;
    out_stall     = 1'b0;
    err_count       = 0;
    sent_count      = 0;
    result_count    = 0;
    hit_count       = 0;
    seg_settings    = 1;
    burst_left      = 0;
    stall_mode      = STALL_NONE;
    stall_mode_left = 0;
    cycle_count     = 0;
    seg_ten_loaded  = 1'b0;
    for (int k = 0; k < 6; k++) endpoints[k] = '0;

    // seg_ten, cx, cy, cz, r, pk, typed, hit
    dir_rows = '{
      // zero-length segment at the origin after reset
      '{1'b0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b1, 1'b1, 1'b1},
      '{1'b0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 1'b0, 1'b1, 1'b0},
      '{1'b0, C_MAX, 32'sd0, 32'sd0, R_MAX, 1'b1, 1'b1, 1'b1},
      '{1'b0, C_MIN, 32'sd0, 32'sd0, R_MAX, 1'b1, 1'b1, 1'b0},
      '{1'b0, C_MIN, C_MIN, C_MIN, R_MAX, 1'b1, 1'b1, 1'b0},
      '{1'b0, C_MAX, C_MAX, C_MAX, R_MAX, 1'b0, 1'b1, 1'b0},
      '{1'b0, 32'sd0, 32'sd1, 32'sd0, 31'd1, 1'b1, 1'b1, 1'b1},
      '{1'b0, 32'sd0, 32'sd1, 32'sd1, 31'd1, 1'b1, 1'b1, 1'b0},
      // segment from the origin to 10.0 on x: behind the start
      '{1'b1, -3 * ONE, 32'sd0, 32'sd0, 31'(3 * ONE), 1'b1, 1'b1, 1'b1},
      '{1'b1, -3 * ONE, 32'sd0, 32'sd0, 31'(3 * ONE - 1), 1'b1, 1'b1, 1'b0},
      // beyond the end
      '{1'b1, 13 * ONE, 32'sd0, 32'sd0, 31'(3 * ONE), 1'b1, 1'b1, 1'b1},
      '{1'b1, 13 * ONE, 32'sd0, 32'sd0, 31'(3 * ONE - 1), 1'b1, 1'b1, 1'b0},
      // midpoint projection, touching and just missing
      '{1'b1, 5 * ONE, 4 * ONE, 32'sd0, 31'(4 * ONE), 1'b1, 1'b1, 1'b1},
      '{1'b1, 5 * ONE, 4 * ONE, 32'sd0, 31'(4 * ONE - 1), 1'b1, 1'b1, 1'b0},
      '{1'b1, 5 * ONE, 32'sd0, 32'sd0, R_MAX, 1'b0, 1'b1, 1'b0},
      '{1'b1, 32'sd216269, -32'sd137626, 32'sd504627, 31'(8 * ONE), 1'b1, 1'b0, 1'b0},
      '{1'b1, C_MAX, C_MAX, C_MAX, R_MAX, 1'b1, 1'b0, 1'b0},
      '{1'b1, C_MIN, C_MIN, C_MIN, 31'd0, 1'b1, 1'b1, 1'b0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int n = 0; n < N_DIR; n++) begin
      if (dir_rows[n].seg_ten && !seg_ten_loaded) begin
        drain_results();
        load_segment(32'sd0, 32'sd0, 32'sd0, 10 * ONE, 32'sd0, 32'sd0);
        seg_ten_loaded = 1'b1;
      end
      s.c[0] = dir_rows[n].cx;
      s.c[1] = dir_rows[n].cy;
      s.c[2] = dir_rows[n].cz;
      s.rad  = dir_rows[n].r;
      s.pk   = dir_rows[n].pk;
      send_sphere(s, dir_rows[n].typed, dir_rows[n].hit);
    end

    // random phases, each under its own segment
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      nx = rand_crd(32);
      ny = rand_crd(32);
      nz = rand_crd(32);
      case (ph)
        0: load_segment(rand_crd(21), rand_crd(21), rand_crd(21),
                        rand_crd(21), rand_crd(21), rand_crd(21));
        1, 6: load_segment(nx, ny, nz, rand_crd(32), rand_crd(32), rand_crd(32));
        2: load_segment(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        3: begin
          load_segment(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
          // unmapped slots must leave the endpoints alone
          write_endpoint(IDX_SPARE_A, $urandom);
          write_endpoint(IDX_SPARE_B, $urandom);
        end
        4: load_segment(nx, ny, nz, nx, ny, nz);
        5: begin
          nx = rand_crd(25);
          load_segment(nx, ny, nz, crd_t'(nx + rand_crd(25)), ny, nz);
        end
        default: begin
          nx = rand_crd(29);
          ny = rand_crd(29);
          nz = rand_crd(29);
          load_segment(nx, ny, nz, crd_t'(nx + rand_crd(8)), crd_t'(ny + rand_crd(8)),
                       crd_t'(nz + rand_crd(8)));
        end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind       = $urandom_range(0, 9);
        tq         = longint'($urandom_range(0, 131072)) - 32768;  // t in [-0.5, 1.5]
        scale_bits = $urandom_range(0, 30);
        for (int k = 0; k < 3; k++) begin
          av = endpoints[k];
          dv = longint'(endpoints[3 + k]) - av;
          if (kind <= 5)
            s.c[k] = clamp_crd(av + ((dv * tq) >>> FRAC_BITS) + rand_crd(scale_bits + 1));
          else if (kind <= 7)
            s.c[k] = crd_t'($urandom);
          else if (kind == 8)
            s.c[k] = clamp_crd(av + rand_crd(4));
          else
            s.c[k] = tq[0] ? endpoints[k] : endpoints[3 + k];
        end
        if (kind <= 5) begin
          rad_v = ((longint'(1) << scale_bits) * $urandom_range(2, 7)) / 4;
          s.rad = (rad_v > longint'(R_MAX)) ? R_MAX : RAD_W'(rad_v);
        end else if (kind <= 7) begin
          s.rad = RAD_W'($urandom);
        end else begin
          s.rad = RAD_W'($urandom_range(0, 15));
        end
        s.pk = ($urandom_range(0, 3) != 0);
        send_sphere(s, 1'b0, 1'b0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("segment_sphere_hit_test_top_tb: %0d spheres over %0d segment settings",
             sent_count, seg_settings);
    $display("segment_sphere_hit_test_top_tb: %0d results checked, %0d hits, %0d mismatches",
             result_count, hit_count, err_count);
    if (err_count == 0) begin
      $display("segment_sphere_hit_test_top_tb: done, clean");
    end else begin
      $display("segment_sphere_hit_test_top_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/segsph_pkg.sv
hw/rtl/segsph_front.sv
hw/rtl/segsph_div.sv
hw/rtl/segsph_back.sv
hw/rtl/segment_sphere_hit_test_top.sv
tb/segment_sphere_hit_test_top_tb.sv
